[design/single_server_queue_event_step_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the single-server queue event step
// Short forms for clocked concurrent checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SINGLE_SERVER_QUEUE_EVENT_STEP_ASSERT_SVH
`define SINGLE_SERVER_QUEUE_EVENT_STEP_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define SSQ_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SSQ_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SSQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/ssq_pkg.sv]
// ----------------------------------------------------------------------------
// ssq_pkg
// Sizes, codes and field layout shared by the single-server queue block.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

   localparam int QUEUE_DEPTH = 2048;
   localparam int TIME_BITS   = 32;

   localparam int PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int SAMPLE_W = 24;

   // Fixed widths of the result fields.
   localparam int OUT_TIME_W = 32;
   localparam int QLEN_W     = 12;
   localparam int COUNT_W    = 32;
   localparam int DSUM_W     = 48;
   localparam int QAREA_W    = 56;
   localparam int BAREA_W    = 48;

   // Widths of the intermediate sums that carry the overflow bits.
   localparam int TSUM_W = ((TIME_BITS > SAMPLE_W) ? TIME_BITS : SAMPLE_W) + 1;
   localparam int PROD_W = CNT_W + TIME_BITS;
   localparam int QSUM_W = ((PROD_W > QAREA_W) ? PROD_W : QAREA_W) + 1;
   localparam int BSUM_W = BAREA_W + 1;
   localparam int DADD_W = DSUM_W + 1;

   localparam int REQ_DATA_W = 2 * SAMPLE_W;
   localparam int RSP_USED_W = OUT_TIME_W + QLEN_W + 1 + OUT_TIME_W + 1 + COUNT_W
                               + DSUM_W + QAREA_W + BAREA_W + 1 + 2;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [COUNT_W-1:0] CUSTOMERS_RESET = COUNT_W'(1000);

   localparam logic REQ_START     = 1'b0;
   localparam logic REQ_ADVANCE   = 1'b1;
   localparam logic EVT_ARRIVAL   = 1'b0;
   localparam logic EVT_DEPARTURE = 1'b1;

   typedef enum logic [1:0] {
      HALT_NONE     = 2'd0,
      HALT_OVERFLOW = 2'd1,
      HALT_TIME     = 2'd2
   } halt_type;

endpackage

`default_nettype wire

[design/ssq_ram.sv]
// ----------------------------------------------------------------------------
// ssq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/single_server_queue_event_step.sv]
// ----------------------------------------------------------------------------
// single_server_queue_event_step
// Discrete-event step of a single-server queue: start a run or advance one
// event, with the waiting arrival times held in a RAM-based FIFO.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  req      in         req_tvalid/req_tready  tdata: samples, tuser: request type
//  rsp      out        rsp_tvalid/rsp_tready  tdata: run state, tuser: event kind
//  csr      in         csr_wr_en              csr_wr_data: customers required
//
//  The acceptance edge commits the step and loads the result register. In the
//  next cycle req_tready is low while the next-event time, the elapsed time and
//  the queue head are registered from the new state, so a head read never meets
//  a FIFO write to the same entry. Reset is synchronous and needs no clearing
//  pass; the first cycle after reset is such a prepare cycle. A stalled result
//  holds req_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "single_server_queue_event_step_assert.svh"

module single_server_queue_event_step (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ssq_pkg::COUNT_W-1:0]      csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // interarrival_sample [23:0], service_sample [47:24]
   input  logic [ssq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type [0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // sim_time [31:0], queue_length [43:32], server_busy [44], delay [76:45],
   // delay_valid [77], customers_delayed [109:78], total_delay [157:110],
   // area_queue [213:158], area_busy [261:214], done_res [262],
   // error_code [264:263], zero fill above
   output logic [ssq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // event_kind [0]
   output logic                             rsp_tuser
);

   import ssq_pkg::*;

   // Run state
   logic [COUNT_W-1:0]   csr_ff;
   logic [TIME_BITS-1:0] clock_ff, clock_in;
   logic [TIME_BITS-1:0] na_ff, na_in;
   logic [TIME_BITS-1:0] nd_ff, nd_in;
   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     wc_ff, wc_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [COUNT_W-1:0]   dc_ff, dc_in;
   logic [DSUM_W-1:0]    dsum_ff, dsum_in;
   logic [QAREA_W-1:0]   qarea_ff, qarea_in;
   logic [BAREA_W-1:0]   barea_ff, barea_in;
   halt_type             halt_ff, halt_in;

   // Result register beyond the run state
   logic                  rsp_valid_ff;
   logic                  kind_ff, kind_in;
   logic [OUT_TIME_W-1:0] dly_ff, dly_in;
   logic                  dval_ff, dval_in;
   logic                  done_ff, done_in;

   // Next-event values prepared from the committed state
   logic                 prep_ff;
   logic                 dep_ff, dep_in;
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [TIME_BITS-1:0] dt_ff, dt_in;

   // FIFO access
   logic                 push;
   logic [TIME_BITS-1:0] ram_rd_data;

   // Datapath
   logic                 req_accept;
   logic [SAMPLE_W-1:0]  ia, sv;
   logic [TSUM_W-1:0]    start_sum, t_ia, t_sv;
   logic                 start_over, ia_over, sv_over;
   logic [TIME_BITS-1:0] dly_t;
   logic [PROD_W-1:0]    qprod;
   logic [QSUM_W-1:0]    qsum;
   logic [BSUM_W-1:0]    bsum;
   logic [DADD_W-1:0]    dadd;
   logic [QAREA_W-1:0]   qarea_acc;
   logic [BAREA_W-1:0]   barea_acc;
   logic [DSUM_W-1:0]    dsum_acc;
   logic [COUNT_W-1:0]   dc_inc;
   logic [PTR_W-1:0]     head_nxt, tail_nxt;
   logic                 full, done_cur;

   assign req_tready = prep_ff && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign ia         = req_tdata[SAMPLE_W-1:0];
   assign sv         = req_tdata[2*SAMPLE_W-1:SAMPLE_W];

   always_comb begin
      dep_in     = busy_ff && (nd_ff < na_ff);
      t_in       = dep_in ? nd_ff : na_ff;
      dt_in      = (t_in > clock_ff) ? (t_in - clock_ff) : '0;
      start_sum  = TSUM_W'(ia);
      t_ia       = TSUM_W'(t_ff) + TSUM_W'(ia);
      t_sv       = TSUM_W'(t_ff) + TSUM_W'(sv);
      start_over = |start_sum[TSUM_W-1:TIME_BITS];
      ia_over    = |t_ia[TSUM_W-1:TIME_BITS];
      sv_over    = |t_sv[TSUM_W-1:TIME_BITS];
      dly_t      = (t_ff > ram_rd_data) ? (t_ff - ram_rd_data) : '0;
      qprod      = PROD_W'(wc_ff) * PROD_W'(dt_ff);
      qsum       = QSUM_W'(qarea_ff) + QSUM_W'(qprod);
      qarea_acc  = (|qsum[QSUM_W-1:QAREA_W]) ? '1 : qsum[QAREA_W-1:0];
      bsum       = BSUM_W'(barea_ff) + BSUM_W'(dt_ff);
      barea_acc  = bsum[BAREA_W] ? '1 : bsum[BAREA_W-1:0];
      dadd       = DADD_W'(dsum_ff) + DADD_W'(dly_t);
      dsum_acc   = dadd[DSUM_W] ? '1 : dadd[DSUM_W-1:0];
      dc_inc     = (&dc_ff) ? dc_ff : dc_ff + COUNT_W'(1);
      head_nxt   = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      tail_nxt   = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      full       = wc_ff >= CNT_W'(QUEUE_DEPTH);
      done_cur   = dc_ff >= csr_ff;
   end

   always_comb begin
      clock_in = clock_ff;
      na_in    = na_ff;
      nd_in    = nd_ff;
      busy_in  = busy_ff;
      wc_in    = wc_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      dc_in    = dc_ff;
      dsum_in  = dsum_ff;
      qarea_in = qarea_ff;
      barea_in = barea_ff;
      halt_in  = halt_ff;
      kind_in  = EVT_ARRIVAL;
      dly_in   = '0;
      dval_in  = 1'b0;
      push     = 1'b0;
      if (req_tuser == REQ_START) begin
         clock_in = '0;
         nd_in    = '0;
         busy_in  = 1'b0;
         wc_in    = '0;
         head_in  = '0;
         tail_in  = '0;
         dc_in    = '0;
         dsum_in  = '0;
         qarea_in = '0;
         barea_in = '0;
         if (start_over) begin
            na_in   = '0;
            halt_in = HALT_TIME;
         end else begin
            na_in   = start_sum[TIME_BITS-1:0];
            halt_in = HALT_NONE;
         end
      end else if (halt_ff == HALT_NONE && !done_cur) begin
         if (!dep_ff) begin
            // Arrival; a full queue is checked before the time limits.
            if (busy_ff && full) begin
               halt_in = HALT_OVERFLOW;
            end else if (ia_over || (!busy_ff && sv_over)) begin
               halt_in = HALT_TIME;
            end else begin
               clock_in = t_ff;
               qarea_in = qarea_acc;
               if (busy_ff) begin
                  barea_in = barea_acc;
               end
               na_in = t_ia[TIME_BITS-1:0];
               if (busy_ff) begin
                  push    = 1'b1;
                  tail_in = tail_nxt;
                  wc_in   = wc_ff + CNT_W'(1);
               end else begin
                  busy_in = 1'b1;
                  nd_in   = t_sv[TIME_BITS-1:0];
                  dc_in   = dc_inc;
                  dval_in = 1'b1;
               end
            end
         end else begin
            if (wc_ff != '0 && sv_over) begin
               halt_in = HALT_TIME;
            end else begin
               clock_in = t_ff;
               qarea_in = qarea_acc;
               barea_in = barea_acc;
               kind_in  = EVT_DEPARTURE;
               if (wc_ff == '0) begin
                  busy_in = 1'b0;
                  nd_in   = '0;
               end else begin
                  head_in = head_nxt;
                  wc_in   = wc_ff - CNT_W'(1);
                  dly_in  = OUT_TIME_W'(dly_t);
                  dsum_in = dsum_acc;
                  dc_in   = dc_inc;
                  nd_in   = t_sv[TIME_BITS-1:0];
                  dval_in = 1'b1;
               end
            end
         end
      end
      done_in = dc_in >= csr_ff;
   end

   // The head is read at the current head pointer every cycle. A write lands
   // at the acceptance edge and the read that feeds the next step is taken at a
   // later edge, so the written entry is always seen.
   ssq_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (req_accept && push),
      .wr_addr (tail_ff),
      .wr_data (t_ff),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= CUSTOMERS_RESET;
         clock_ff     <= '0;
         na_ff        <= '0;
         nd_ff        <= '0;
         busy_ff      <= 1'b0;
         wc_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         dc_ff        <= '0;
         dsum_ff      <= '0;
         qarea_ff     <= '0;
         barea_ff     <= '0;
         halt_ff      <= HALT_NONE;
         rsp_valid_ff <= 1'b0;
         prep_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         prep_ff <= !req_accept;
         if (req_accept) begin
            clock_ff     <= clock_in;
            na_ff        <= na_in;
            nd_ff        <= nd_in;
            busy_ff      <= busy_in;
            wc_ff        <= wc_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            dc_ff        <= dc_in;
            dsum_ff      <= dsum_in;
            qarea_ff     <= qarea_in;
            barea_ff     <= barea_in;
            halt_ff      <= halt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dep_ff <= dep_in;
      t_ff   <= t_in;
      dt_ff  <= dt_in;
      if (req_accept) begin
         kind_ff <= kind_in;
         dly_ff  <= dly_in;
         dval_ff <= dval_in;
         done_ff <= done_in;
      end
   end

   // The run state only moves on acceptance, so it is the result while
   // the output register holds an item.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                        halt_ff, done_ff, barea_ff, qarea_ff, dsum_ff, dc_ff,
                        dval_ff, dly_ff, busy_ff, QLEN_W'(wc_ff),
                        OUT_TIME_W'(clock_ff)};

   `SSQ_ASSERT_ALWAYS(a_wc_bound, clock, reset, wc_ff <= CNT_W'(QUEUE_DEPTH),
      "queue count beyond depth")
   `SSQ_ASSERT_IMPLIES(a_idle_empty, clock, reset, !busy_ff, wc_ff == '0,
      "idle server with waiting items")
   `SSQ_ASSERT_IMPLIES(a_empty_ptrs, clock, reset, wc_ff == '0, head_ff == tail_ff,
      "empty queue with unequal pointers")
   `SSQ_ASSERT_NEXT(a_halt_hold, clock, reset,
      req_accept && req_tuser == REQ_ADVANCE && halt_ff != HALT_NONE,
      $stable(clock_ff) && $stable(dc_ff), "halted run changed state")
   `SSQ_ASSERT_IMPLIES(a_dval_busy, clock, reset, rsp_valid_ff && dval_ff, busy_ff,
      "delay reported with idle server")
   `SSQ_ASSERT_NEXT(a_prep_gap, clock, reset, req_accept, !req_tready,
      "item accepted during the prepare cycle")

endmodule

`default_nettype wire
